/* rtl/core/swes_pkg.sv */
package swes_pkg;

    localparam int unsigned DEFAULT_STACK_DEPTH = 128;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned FILL_W    = 8;
    localparam int unsigned LARGEST_W = 31;

    localparam logic signed [WORD_W-1:0] SMALL_CEILING = 32'sd100000;

    // request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [WORD_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] popped_value;
        logic [FILL_W-1:0]        fill_count;
        logic [LARGEST_W-1:0]     largest;
        logic signed [WORD_W-1:0] smallest;
        logic                     found;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // take request, update stack, read top for pop
        logic begin_scan;  // capture popped word, clear accumulators
        logic issue;       // read entry at scan index, advance index
        logic accumulate;  // fold the word read last cycle
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;       // no entries held
        logic idx_done;    // every held entry has been read
    } dp_status_t;

endpackage

/* rtl/core/swes_ctrl.sv */
module swes_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    input  swes_pkg::dp_status_t  stat,
    output swes_pkg::dp_cmd_t     cmd
);
    import swes_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.begin_scan = 1'b1;
                if (stat.empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.accumulate = 1'b1;
                if (stat.idx_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe not followed by idle");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.begin_scan) || $past(cmd.accumulate))
        else $error("result strobe without a preceding scan");
`endif

endmodule

/* rtl/core/swes_datapath.sv */
module swes_datapath #(
    parameter int unsigned STACK_DEPTH = swes_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swes_pkg::dp_cmd_t     cmd,
    output swes_pkg::dp_status_t  stat,
    input  swes_pkg::req_t        req,
    output swes_pkg::result_t     result
);
    import swes_pkg::*;

    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [WORD_W-1:0]        mem [0:STACK_DEPTH-1];
    logic signed [WORD_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [1:0]               kind_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [1:0]               status_reg;
    logic signed [WORD_W-1:0] popped_reg;
    logic [LARGEST_W-1:0]     hi_reg;
    logic signed [WORD_W-1:0] lo_reg;
    logic                     found_reg;

    logic                     full;
    logic                     empty;
    logic [CNT_W-1:0]         top_idx;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     do_push;
    logic                     do_pop;

    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign top_idx = count_reg - CNT_W'(1);
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign rd_addr = cmd.load ? top_idx[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign do_push = cmd.load && (req.req_type == REQ_PUSH) && !full;
    assign do_pop  = cmd.load && (req.req_type == REQ_POP) && !empty;

    // storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_addr] <= req.item_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop)
            begin
                count_reg <= top_idx;
            end

            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= req.req_type;
            value_reg  <= req.item_value;
            popped_reg <= '0;
            if ((req.req_type == REQ_PUSH) && full)
            begin
                status_reg <= ST_FULL;
            end
            else if ((req.req_type == REQ_POP) && empty)
            begin
                status_reg <= ST_EMPTY;
            end
            else
            begin
                status_reg <= ST_DONE;
            end
        end

        if (cmd.begin_scan)
        begin
            hi_reg    <= '0;
            lo_reg    <= SMALL_CEILING;
            found_reg <= 1'b0;
            if ((kind_reg == REQ_POP) && (status_reg == ST_DONE))
            begin
                popped_reg <= rd_data_reg;
            end
        end
        else if (cmd.accumulate)
        begin
            if (!rd_data_reg[WORD_W-1] && (rd_data_reg[LARGEST_W-1:0] > hi_reg))
            begin
                hi_reg <= rd_data_reg[LARGEST_W-1:0];
            end
            if (rd_data_reg < lo_reg)
            begin
                lo_reg <= rd_data_reg;
            end
            if ((kind_reg == REQ_CHECK) && (rd_data_reg == value_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    assign stat.empty    = empty;
    assign stat.idx_done = (idx_reg == count_reg);

    assign result.status       = status_reg;
    assign result.popped_value = popped_reg;
    assign result.fill_count   = FILL_W'(count_reg);
    assign result.largest      = hi_reg;
    assign result.smallest     = lo_reg;
    assign result.found        = found_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("fill count above stack depth");

    a_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("scan index ran past the fill count");

    a_count_stable_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue || cmd.accumulate |=> $stable(count_reg))
        else $error("fill count changed during a scan");
`endif

endmodule

/* rtl/core/stack_with_extrema_and_search_top.sv */
// done strobes once the scan of all N entries held after the request is over.
// A new request is taken only while idle (busy low); the scan reads one stored entry
//   per cycle through the single read port for extrema and search.
// Result is valid with done high and held until the next accept; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the stack and returns to idle;
//   stored words are not cleared and are never used before written.
module stack_with_extrema_and_search_top #(
    parameter int unsigned STACK_DEPTH = swes_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  swes_pkg::req_t    req,
    output logic              done,
    output swes_pkg::result_t result
);
    import swes_pkg::*;

    // Controller sequences each transfer: idle -> fetch -> scan -> done (no scan when empty).
    // Push/pop update the stack on the accepting edge; pop reads the top word
    // at the same edge. The scan then walks entries 0..N-1 through the
    // registered read port, folding max of non-negative words, min and match per cycle.
    dp_cmd_t    cmd;
    dp_status_t stat;

    swes_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    swes_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .req    (req),
        .result (result)
    );

endmodule
